[design/smx_pkg.sv]
// Package: payload types, codes and defaults for the two-track sample mixer.
`timescale 1ns / 1ps
package smx_pkg;

  localparam int unsigned SMX_STORE_WORDS = 8192;

  localparam int unsigned ADDR_W   = 13;
  localparam int unsigned LEN_W    = 14;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned MIX_W    = 15;
  localparam int unsigned TRACKS   = 2;
  localparam int unsigned CFG_W    = 14;
  localparam int unsigned CFG_IDX_W = 2;

  // Item kinds carried in the action field.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_A_START  = 2'd0,
    CFG_CLIP_A_LENGTH = 2'd1,
    CFG_CLIP_B_START  = 2'd2,
    CFG_CLIP_B_LENGTH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                     action;
    logic [ADDR_W-1:0]        load_address;
    logic signed [WORD_W-1:0] load_value;
    logic [TRACKS-1:0]        trigger;
  } smx_in_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mixed_sample;
    logic [TRACKS-1:0]       playing_mask;
  } smx_out_t;

endpackage

[design/smx_store.sv]
// Sample store: synchronous memory with one write port and one registered read port.
`timescale 1ns / 1ps
module smx_store #(
  parameter int unsigned WORDS = 8192,
  parameter int unsigned AW    = $clog2(WORDS)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [WORDS];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old word on a same-address write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/two_track_sample_mixer_unit.sv]
// Top level of the two-track sample mixer: track sequencing, mixing and handshakes.
`timescale 1ns / 1ps
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -----------------------------
//  in       input      in_valid_i / in_stall_o   smx_in_t  (load or tick)
//  out      output     out_valid_o / out_stall_i smx_out_t (one per tick)
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
//  A load transaction writes its word at the accepting edge.
//  A tick transaction reads its two track words one per cycle through the
//  single read port of the sample store; the next tick may be accepted in the mix step.
//  The result moves through the second-read and mix states into the output register.
//  Reset clears track state, the pipeline control and the clip registers (starts 0,
//  lengths 1); the sample store is not cleared.
//  A stalled result holds in the output register; input stalls only while the
//  second read is in flight or while a finished mix waits for that register.
//
module two_track_sample_mixer_unit #(
  parameter int unsigned STORE_WORDS = smx_pkg::SMX_STORE_WORDS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  smx_pkg::smx_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output smx_pkg::smx_out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [smx_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [smx_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import smx_pkg::*;

  // Store addresses wrap to the store size (a power of two).
  localparam int unsigned AW = $clog2(STORE_WORDS);
  // Wide enough for start plus offset, and for any store address.
  localparam int unsigned XW = (AW > ADDR_W + 2) ? AW : ADDR_W + 2;

  // Sequencer codes.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READB = 2'd1;
  localparam logic [1:0] ST_SUM   = 2'd2;

  logic [1:0] state_q, state_d;

  // Clip registers.
  logic [ADDR_W-1:0] start_q [TRACKS];
  logic [LEN_W-1:0]  len_q   [TRACKS];

  // Track state.
  logic [LEN_W-1:0]  off_q  [TRACKS];
  logic [LEN_W-1:0]  off_d  [TRACKS];
  logic [TRACKS-1:0] act_q, act_d;

  // Per-tick pipeline.
  logic [TRACKS-1:0] use_q, use_d;
  logic [TRACKS-1:0] mask_q, mask_d;
  logic [AW-1:0]     addr_b_q;
  logic [AW-1:0]     trk_addr [TRACKS];
  logic [15:0]       word_a_q;
  logic [15:0]       rdata;

  // Output register.
  logic     out_valid_q;
  smx_out_t out_q;

  logic          in_acc, tick_acc, load_acc, out_free, push;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [XW-1:0] load_ext;
  logic [AW-1:0] load_addr;

  logic signed [WORD_W:0]   sum;
  logic signed [WORD_W-1:0] sat;
  logic signed [WORD_W:0]   bias;
  logic signed [MIX_W-1:0]  half;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign push       = (state_q == ST_SUM) && out_free;
  // Hold input while the second read is in flight or a mix waits for the output slot.
  assign in_stall_o = (state_q == ST_READB) || ((state_q == ST_SUM) && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (in_data_i.action == ACT_TICK);
  assign load_acc   = in_acc && (in_data_i.action == ACT_LOAD);

  assign load_ext  = XW'(in_data_i.load_address);
  assign load_addr = load_ext[AW-1:0];

  // Apply triggers, pick each track's address and advance its offset, all at
  // the accepting edge; the sample words follow through the store.
  always_comb begin
    logic [TRACKS-1:0] eff_act;
    logic [LEN_W-1:0]  eff_off;
    logic [LEN_W-1:0]  nxt_off;
    logic [XW-1:0]     full_addr;
    eff_act = '0;
    eff_off = '0;
    nxt_off = '0;
    full_addr = '0;
    act_d  = act_q;
    use_d  = use_q;
    mask_d = mask_q;
    for (int t = 0; t < TRACKS; t++) begin
      off_d[t]   = off_q[t];
      eff_act[t] = act_q[t] || in_data_i.trigger[t];
      eff_off    = in_data_i.trigger[t] ? '0 : off_q[t];
      full_addr  = XW'(start_q[t]) + XW'(eff_off);
      trk_addr[t] = full_addr[AW-1:0];
      nxt_off    = eff_off + LEN_W'(1);
      if (tick_acc) begin
        use_d[t] = eff_act[t];
        if (eff_act[t]) begin
          off_d[t] = nxt_off;
          act_d[t] = !((nxt_off >= len_q[t]) || (nxt_off == '0));
        end
        mask_d[t] = act_d[t];
      end
    end
  end

  // First read at the accepting edge, second read in the following cycle.
  assign rd_en   = tick_acc || (state_q == ST_READB);
  assign rd_addr = tick_acc ? trk_addr[0] : addr_b_q;

  smx_store #(
    .WORDS(STORE_WORDS),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (load_acc),
    .waddr_i(load_addr),
    .wdata_i(in_data_i.load_value),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    if (tick_acc) begin
      state_d = ST_READB;
    end else begin
      case (state_q)
        ST_IDLE:  state_d = ST_IDLE;
        ST_READB: state_d = ST_SUM;
        ST_SUM:   state_d = push ? ST_IDLE : ST_SUM;
        default:  state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      act_q   <= '0;
      use_q   <= '0;
      mask_q  <= '0;
      for (int t = 0; t < TRACKS; t++) begin
        off_q[t]   <= '0;
        start_q[t] <= '0;
        len_q[t]   <= LEN_W'(1);
      end
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      use_q   <= use_d;
      mask_q  <= mask_d;
      for (int t = 0; t < TRACKS; t++) begin
        off_q[t] <= off_d[t];
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_CLIP_A_START:  start_q[0] <= cfg_wdata_i[ADDR_W-1:0];
          CFG_CLIP_A_LENGTH: len_q[0]   <= cfg_wdata_i[LEN_W-1:0];
          CFG_CLIP_B_START:  start_q[1] <= cfg_wdata_i[ADDR_W-1:0];
          CFG_CLIP_B_LENGTH: len_q[1]   <= cfg_wdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      addr_b_q <= trk_addr[1];
    end
    if (state_q == ST_READB) begin
      word_a_q <= rdata;
    end
  end

  // Mix: add the words of the tracks in use, saturate, halve toward zero.
  always_comb begin
    sum = (use_q[0] ? {word_a_q[15], word_a_q} : '0)
        + (use_q[1] ? {rdata[15], rdata} : '0);
    if (sum > 17'sd32767) begin
      sat = 16'sh7FFF;
    end else if (sum < -17'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[WORD_W-1:0];
    end
    bias = {sat[15], sat} + {16'd0, sat[15]};
    half = bias[MIX_W:1];
  end

  // Output register: load on push, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q.mixed_sample <= half;
      out_q.playing_mask <= mask_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A tick always moves on to the second read.
  a_tick_to_readb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> state_q == ST_READB)
    else $error("tick did not start second read");

  // The second read is always followed by the mix step.
  a_readb_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READB |=> state_q == ST_SUM)
    else $error("second read not followed by mix");

  // A finished mix waits while the output slot is occupied.
  a_sum_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) && !out_free |=> state_q == ST_SUM)
    else $error("mix dropped while output blocked");

  // An idle track without a trigger stays idle.
  a_idle_track0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !act_q[0] && !(tick_acc && in_data_i.trigger[0]) |=> !act_q[0])
    else $error("track zero started without trigger");

endmodule
